// ----- hdl/wmsf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the module section framer.
package wmsf_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_ID      = 3'd2,
        PH_SIZE    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    // Record kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_SECTION = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_MAGIC   = 2'd1;
    localparam logic [1:0] ERR_VERSION = 2'd2;
    localparam logic [1:0] ERR_BOUNDS  = 2'd3;

    // Magic "\0asm", first byte in the low lane
    localparam logic [31:0] MAGIC_WORD      = 32'h6D73_6100;
    localparam logic [31:0] VERSION_ONE     = 32'h0000_0001;
    localparam logic [31:0] MIN_LENGTH      = 32'd8;
    localparam logic [31:0] LAST_MAGIC_POS  = 32'd3;
    localparam logic [31:0] LAST_HEADER_POS = 32'd7;
    localparam logic [2:0]  LEB_MAX_BYTES   = 3'd5;
    localparam logic [4:0]  LEB_DIGIT_BITS  = 5'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_module;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  section_id;
        logic [31:0] section_size;
        logic [31:0] payload_offset;
        logic [31:0] module_version;
        logic [1:0]  error_code;
        logic        module_done;
    } out_word_t;

endpackage

// ----- hdl/wasm_module_section_framer.sv -----
`timescale 1ns / 1ps
// Top level of the module section framer: input register, parser, result register.
// The framer takes one module byte per cycle and gives at most one record per byte:
// an accepted byte waits in the input register, then the parser state and the result
// register are updated together. A byte is taken every cycle while the result register
// is free or being drained; in_stall rises only when both the input register and the
// result register are full and out_stall is high.
// Write module_length through cfg_write/cfg_data while no byte is in flight.
module wasm_module_section_framer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  wmsf_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output wmsf_pkg::out_word_t out_word
);

    logic [31:0]         module_length_reg;
    logic                in_valid_reg;
    wmsf_pkg::in_word_t  in_word_reg;
    logic                out_valid_reg;
    wmsf_pkg::out_word_t out_word_reg;

    wmsf_pkg::phase_t    phase_reg, phase_next;
    logic [31:0]         pos_reg, pos_next;
    logic [31:0]         acc_reg, acc_next;
    logic [2:0]          shift_reg, shift_next;
    logic [7:0]          id_reg, id_next;
    logic [31:0]         rem_reg, rem_next;
    logic [31:0]         ver_reg, ver_next;

    logic                advance;
    logic                emit;
    wmsf_pkg::out_word_t rec;

    // Effective state after an optional start-of-module clear
    wmsf_pkg::phase_t    phase_eff;
    logic [31:0]         pos_eff, acc_eff, rem_eff, ver_eff;
    logic [2:0]          shift_eff;
    logic [7:0]          id_eff;

    logic [7:0]          b;
    logic [32:0]         next33;
    logic [33:0]         end34;
    logic [31:0]         leb_new;
    logic [31:0]         rem_dec;
    logic                last_byte;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Hold the configured module length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_length_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            module_length_reg <= cfg_data;
        end
    end

    // Capture the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_word_reg <= in_word;
        end
    end

    // Advance parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wmsf_pkg::PH_MAGIC;
            pos_reg   <= 32'd0;
            acc_reg   <= 32'd0;
            shift_reg <= 3'd0;
            id_reg    <= 8'd0;
            rem_reg   <= 32'd0;
            ver_reg   <= 32'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            id_reg    <= id_next;
            rem_reg   <= rem_next;
            ver_reg   <= ver_next;
        end
    end

    // Load or drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_word_reg <= rec;
        end
    end

    // Parse one byte
    always_comb
    begin
        b = in_word_reg.data_byte;

        if (in_word_reg.start_of_module)
        begin
            phase_eff = wmsf_pkg::PH_MAGIC;
            pos_eff   = 32'd0;
            acc_eff   = 32'd0;
            shift_eff = 3'd0;
            id_eff    = 8'd0;
            rem_eff   = 32'd0;
            ver_eff   = 32'd0;
        end
        else
        begin
            phase_eff = phase_reg;
            pos_eff   = pos_reg;
            acc_eff   = acc_reg;
            shift_eff = shift_reg;
            id_eff    = id_reg;
            rem_eff   = rem_reg;
            ver_eff   = ver_reg;
        end

        next33    = {1'b0, pos_eff} + 33'd1;
        last_byte = next33 >= {1'b0, module_length_reg};

        // Fold in one LEB128 digit; digits past the fifth are dropped
        leb_new = acc_eff;
        if (shift_eff < wmsf_pkg::LEB_MAX_BYTES)
        begin
            leb_new = acc_eff
                | ({25'd0, b[6:0]} << (5'(shift_eff) * wmsf_pkg::LEB_DIGIT_BITS));
        end
        end34   = {1'b0, next33} + {2'b00, leb_new};
        rem_dec = (rem_eff != 32'd0) ? rem_eff - 32'd1 : rem_eff;

        phase_next = phase_eff;
        pos_next   = (pos_eff == 32'hFFFF_FFFF) ? pos_eff : next33[31:0];
        acc_next   = acc_eff;
        shift_next = shift_eff;
        id_next    = id_eff;
        rem_next   = rem_eff;
        ver_next   = ver_eff;

        emit               = 1'b0;
        rec.record_kind    = wmsf_pkg::KIND_HEADER;
        rec.section_id     = 8'd0;
        rec.section_size   = 32'd0;
        rec.payload_offset = 32'd0;
        rec.error_code     = wmsf_pkg::ERR_NONE;
        rec.module_done    = 1'b0;

        unique case (phase_eff)
            wmsf_pkg::PH_MAGIC:
            begin
                if ((pos_eff == 32'd0 && module_length_reg < wmsf_pkg::MIN_LENGTH)
                    || b != wmsf_pkg::MAGIC_WORD[pos_eff[1:0]*8 +: 8])
                begin
                    phase_next      = wmsf_pkg::PH_DONE;
                    emit            = 1'b1;
                    rec.record_kind = wmsf_pkg::KIND_ERROR;
                    rec.error_code  = wmsf_pkg::ERR_MAGIC;
                    rec.module_done = 1'b1;
                end
                else if (pos_eff >= wmsf_pkg::LAST_MAGIC_POS)
                begin
                    phase_next = wmsf_pkg::PH_VERSION;
                end
            end
            wmsf_pkg::PH_VERSION:
            begin
                ver_next = ver_eff | ({24'd0, b} << {pos_eff[1:0], 3'b000});
                if (pos_eff >= wmsf_pkg::LAST_HEADER_POS)
                begin
                    emit = 1'b1;
                    if (ver_next != wmsf_pkg::VERSION_ONE)
                    begin
                        phase_next      = wmsf_pkg::PH_DONE;
                        rec.record_kind = wmsf_pkg::KIND_ERROR;
                        rec.error_code  = wmsf_pkg::ERR_VERSION;
                        rec.module_done = 1'b1;
                    end
                    else if (last_byte)
                    begin
                        phase_next      = wmsf_pkg::PH_DONE;
                        rec.module_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = wmsf_pkg::PH_ID;
                    end
                end
            end
            wmsf_pkg::PH_ID:
            begin
                if (pos_eff >= module_length_reg)
                begin
                    phase_next = wmsf_pkg::PH_DONE;
                end
                else
                begin
                    id_next    = b;
                    acc_next   = 32'd0;
                    shift_next = 3'd0;
                    if (last_byte)
                    begin
                        phase_next      = wmsf_pkg::PH_DONE;
                        emit            = 1'b1;
                        rec.record_kind = wmsf_pkg::KIND_ERROR;
                        rec.section_id  = b;
                        rec.error_code  = wmsf_pkg::ERR_BOUNDS;
                        rec.module_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = wmsf_pkg::PH_SIZE;
                    end
                end
            end
            wmsf_pkg::PH_SIZE:
            begin
                rec.section_id = id_eff;
                if (pos_eff >= module_length_reg)
                begin
                    phase_next       = wmsf_pkg::PH_DONE;
                    emit             = 1'b1;
                    rec.record_kind  = wmsf_pkg::KIND_ERROR;
                    rec.section_size = acc_eff;
                    rec.error_code   = wmsf_pkg::ERR_BOUNDS;
                    rec.module_done  = 1'b1;
                end
                else
                begin
                    acc_next         = leb_new;
                    rec.section_size = leb_new;
                    if (shift_eff < wmsf_pkg::LEB_MAX_BYTES)
                    begin
                        shift_next = shift_eff + 3'd1;
                    end
                    if (b[7])
                    begin
                        if (last_byte)
                        begin
                            phase_next      = wmsf_pkg::PH_DONE;
                            emit            = 1'b1;
                            rec.record_kind = wmsf_pkg::KIND_ERROR;
                            rec.error_code  = wmsf_pkg::ERR_BOUNDS;
                            rec.module_done = 1'b1;
                        end
                    end
                    else if (end34 > {2'b00, module_length_reg})
                    begin
                        phase_next      = wmsf_pkg::PH_DONE;
                        emit            = 1'b1;
                        rec.record_kind = wmsf_pkg::KIND_ERROR;
                        rec.error_code  = wmsf_pkg::ERR_BOUNDS;
                        rec.module_done = 1'b1;
                    end
                    else
                    begin
                        emit               = 1'b1;
                        rem_next           = leb_new;
                        rec.record_kind    = wmsf_pkg::KIND_SECTION;
                        rec.payload_offset = next33[31:0];
                        rec.module_done    = (end34 == {2'b00, module_length_reg});
                        if (leb_new != 32'd0)
                        begin
                            phase_next = wmsf_pkg::PH_PAYLOAD;
                        end
                        else if (rec.module_done)
                        begin
                            phase_next = wmsf_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = wmsf_pkg::PH_ID;
                        end
                    end
                end
            end
            wmsf_pkg::PH_PAYLOAD:
            begin
                rem_next = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    phase_next = last_byte ? wmsf_pkg::PH_DONE : wmsf_pkg::PH_ID;
                end
            end
            wmsf_pkg::PH_DONE:
            begin
                // Drop the byte and hold the position
                pos_next = pos_eff;
            end
            default:
            begin
                pos_next   = pos_eff;
                phase_next = wmsf_pkg::PH_DONE;
            end
        endcase

        rec.module_version = ver_next;
    end

    // A record that ends the module leaves the parser finished or skipping the last payload
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && rec.module_done)
        |=> (phase_reg == wmsf_pkg::PH_DONE || phase_reg == wmsf_pkg::PH_PAYLOAD))
        else $error("module_done record did not finish the parser");

    // Every error record ends the module
    a_error_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.record_kind == wmsf_pkg::KIND_ERROR)
        |-> out_word_reg.module_done)
        else $error("error record without module_done");

    // A finished parser drops bytes until a new start mark
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == wmsf_pkg::PH_DONE && !in_word_reg.start_of_module)
        |=> (!out_valid_reg && phase_reg == wmsf_pkg::PH_DONE))
        else $error("record emitted after module end");

    // Byte position never moves backward within a module
    a_pos_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_word_reg.start_of_module) |=> (pos_reg >= $past(pos_reg)))
        else $error("byte position moved backward");

endmodule
